>>> design/assert_macros.svh
// Shared assertion macros, sampled on the rising clock edge, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in every cycle
`define CHK_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Condition in one cycle implies a consequence in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/srpk_pkg.sv
package srpk_pkg;

   localparam int MaxRects   = 64;
   localparam int AddrW      = 6;
   localparam int CountW     = 7;
   localparam int DimW       = 16;
   localparam int IdxW       = 6;
   localparam int CsrAddrW   = 2;
   localparam int ReqDataW   = 48;
   localparam int RspDataW   = 88;

   localparam logic [CsrAddrW-1:0] CSR_BIN_WIDTH  = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_BIN_HEIGHT = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_BIN_NUMBER = 2'd2;

   // One stored rectangle, lowest field last
   typedef struct packed {
      logic [DimW-1:0] owner;
      logic [DimW-1:0] ypos;
      logic [DimW-1:0] xpos;
      logic [DimW-1:0] height;
      logic [DimW-1:0] width;
      logic [IdxW-1:0] idx;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b00000001,
      ST_INS_RD  = 8'b00000010,
      ST_INS_CMP = 8'b00000100,
      ST_PACK    = 8'b00001000,
      ST_PASS_RD = 8'b00010000,
      ST_PASS_EV = 8'b00100000,
      ST_OUT_RD  = 8'b01000000,
      ST_OUT     = 8'b10000000
   } state_type;

endpackage

>>> design/shelf_rectangle_packer_unit.sv
// Channel   Dir  Handshake          Payload
// req_      in   tvalid/tready      tdata: rect_width, rect_height, prior_bin; tlast: last_rect
// rsp_      out  tvalid/tready      tdata: orig_index .. owner_bin; tlast: last_out
// csr_      in   we, one cycle      addr: register, wdata: value
// Loading a request reads each stored entry of greater height and moves it up one place,
// then writes the new entry into the place left free; the insertion keeps the store
// sorted by height through the single RAM port pair.
// Packing sets up in ST_PACK, then reads and evaluates every entry in each shelf pass;
// each result is read and then held on the response channel until it is taken.
// Synchronous reset clears control state and bin size, sets bin number 1; the store needs no sweep.
// Requests are taken only while idle; a stalled result holds the block.
module shelf_rectangle_packer_unit
   import srpk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // rect_width, rect_height, prior_bin
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,  // orig_index, out_width, out_height, pos_x,
                                           // pos_y, owner_bin, two zero bits
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [DimW-1:0]     csr_wdata
);

   state_type         state_ff, state_in;
   logic [DimW-1:0]   bin_w_ff, bin_h_ff, bin_n_ff;
   logic [CountW-1:0] count_ff, count_in;
   entry_type         new_ff, new_in;
   logic              last_ff, last_in;
   logic [AddrW-1:0]  ptr_ff, ptr_in;
   logic [DimW-1:0]   shelf_ff, shelf_in;
   logic [DimW-1:0]   cur_x_ff, cur_x_in;
   logic [DimW-1:0]   tall_ff, tall_in;
   logic              skip_ff, skip_in;

   logic              wr_en, rd_en;
   logic [AddrW-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   entry_type         placed;
   logic [DimW:0]     y_sum, x_sum;
   logic              fits, free;
   logic [CountW-1:0] count_m1;

   srpk_ram #(.WIDTH(EntryW), .DEPTH(MaxRects)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {2'b00, rd_data};
   assign count_m1   = count_ff - CountW'(1);
   assign rsp_tlast  = ({1'b0, ptr_ff} == count_m1);

   assign y_sum = {1'b0, shelf_ff} + {1'b0, rd_data.height};
   assign x_sum = {1'b0, cur_x_ff} + {1'b0, rd_data.width};
   assign free  = (rd_data.owner == '0);
   assign fits  = (y_sum <= {1'b0, bin_h_ff}) && (x_sum <= {1'b0, bin_w_ff});

   always_comb begin
      placed       = rd_data;
      placed.xpos  = cur_x_ff;
      placed.ypos  = shelf_ff;
      placed.owner = bin_n_ff;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      new_in   = new_ff;
      last_in  = last_ff;
      ptr_in   = ptr_ff;
      shelf_in = shelf_ff;
      cur_x_in = cur_x_ff;
      tall_in  = tall_ff;
      skip_in  = skip_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = new_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in = req_tlast;
               if (count_ff < CountW'(MaxRects)) begin
                  new_in.idx    = count_ff[AddrW-1:0];
                  new_in.width  = req_tdata[15:0];
                  new_in.height = req_tdata[31:16];
                  new_in.owner  = req_tdata[47:32];
                  new_in.xpos   = '0;
                  new_in.ypos   = '0;
                  ptr_in        = count_ff[AddrW-1:0];
                  state_in      = ST_INS_RD;
               end else if (req_tlast) begin
                  state_in = ST_PACK;
               end
            end
         end
         ST_INS_RD: begin
            if (ptr_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CountW'(1);
               state_in = last_ff ? ST_PACK : ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff - AddrW'(1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_data.height > new_ff.height) begin
               // move the taller entry up one place
               wr_data  = rd_data;
               ptr_in   = ptr_ff - AddrW'(1);
               state_in = ST_INS_RD;
            end else begin
               count_in = count_ff + CountW'(1);
               state_in = last_ff ? ST_PACK : ST_IDLE;
            end
         end
         ST_PACK: begin
            shelf_in = '0;
            ptr_in   = count_m1[AddrW-1:0];
            cur_x_in = '0;
            tall_in  = '0;
            skip_in  = 1'b0;
            state_in = ST_PASS_RD;
         end
         ST_PASS_RD: begin
            rd_en    = 1'b1;
            state_in = ST_PASS_EV;
         end
         ST_PASS_EV: begin
            if (free) begin
               if (fits) begin
                  wr_en    = 1'b1;
                  wr_data  = placed;
                  cur_x_in = x_sum[DimW-1:0];
                  if (rd_data.height > tall_ff) begin
                     tall_in = rd_data.height;
                  end
               end else begin
                  skip_in = 1'b1;
               end
            end
            if (ptr_ff == '0) begin
               if (skip_in && (tall_in != '0)) begin
                  // raise the shelf and start another pass from the tallest entry
                  shelf_in = shelf_ff + tall_in;
                  ptr_in   = count_m1[AddrW-1:0];
                  cur_x_in = '0;
                  tall_in  = '0;
                  skip_in  = 1'b0;
                  state_in = ST_PASS_RD;
               end else begin
                  // read entry 0 only after this cycle's write has landed
                  ptr_in   = '0;
                  state_in = ST_OUT_RD;
               end
            end else begin
               ptr_in   = ptr_ff - AddrW'(1);
               state_in = ST_PASS_RD;
            end
         end
         ST_OUT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (rsp_tlast) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next result; valid drops in ST_OUT_RD while it is read
                  ptr_in   = ptr_ff + AddrW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         bin_w_ff <= '0;
         bin_h_ff <= '0;
         bin_n_ff <= DimW'(1);
         last_ff  <= 1'b0;
         ptr_ff   <= '0;
         shelf_ff <= '0;
         cur_x_ff <= '0;
         tall_ff  <= '0;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         ptr_ff   <= ptr_in;
         shelf_ff <= shelf_in;
         cur_x_ff <= cur_x_in;
         tall_ff  <= tall_in;
         skip_ff  <= skip_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BIN_WIDTH:  bin_w_ff <= csr_wdata;
               CSR_BIN_HEIGHT: bin_h_ff <= csr_wdata;
               CSR_BIN_NUMBER: bin_n_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      new_ff <= new_in;
   end

endmodule

>>> design/srpk_ram.sv
module srpk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/srpk_checker.sv
`include "assert_macros.svh"

module srpk_assert
   import srpk_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [ReqDataW-1:0] req_tdata,
   input logic                req_tlast,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tlast,
   input logic                csr_we,
   input logic [CsrAddrW-1:0] csr_addr,
   input logic [DimW-1:0]     csr_wdata
);

   `CHK_NEXT(rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CHK_NEXT(rsp_last_hold, rsp_tvalid && !rsp_tready, $stable(rsp_tlast))
   `CHK_ALWAYS(no_overlap, !(req_tready && rsp_tvalid))
   `CHK_NEXT(run_end, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid && req_tready)
   `CHK_NEXT(fetch_gap, rsp_tvalid && rsp_tready && !rsp_tlast, !rsp_tvalid && !req_tready)

endmodule

bind shelf_rectangle_packer_unit srpk_assert u_srpk_assert (.*);

>>> tb/srpk_checker.sv
module srpk_checker
   import srpk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [DimW-1:0]     csr_wdata,
   output int                  mismatch_count,
   output int                  placements_due,
   output int                  placements_seen
);

   typedef struct packed {
      logic [IdxW-1:0] idx;
      logic [DimW-1:0] width;
      logic [DimW-1:0] height;
      logic [DimW-1:0] xpos;
      logic [DimW-1:0] ypos;
      logic [DimW-1:0] owner;
      logic            last;
   } placement_type;

   logic [DimW-1:0] bin_w, bin_h, bin_id;
   logic [DimW-1:0] w_st[MaxRects], h_st[MaxRects], o_st[MaxRects];
   logic [DimW-1:0] x_st[MaxRects], y_st[MaxRects];
   logic [IdxW-1:0] i_st[MaxRects];
   int              held;
   placement_type   placements_q[$];

   // stable insertion sort by height, then shelf fill from tallest down
   task automatic pack_set();
      logic [DimW-1:0] tw, th, to, tx, ty;
      logic [IdxW-1:0] ti;
      int              j;
      int unsigned     shelf, cur_x;
      int              tallest;
      bit              skipped;
      placement_type   p;
      for (int i = 1; i < held; i++) begin
         tw = w_st[i]; th = h_st[i]; to = o_st[i]; tx = x_st[i]; ty = y_st[i]; ti = i_st[i];
         j = i;
         while (j > 0 && h_st[j-1] > th) begin
            w_st[j] = w_st[j-1]; h_st[j] = h_st[j-1]; o_st[j] = o_st[j-1];
            x_st[j] = x_st[j-1]; y_st[j] = y_st[j-1]; i_st[j] = i_st[j-1];
            j--;
         end
         w_st[j] = tw; h_st[j] = th; o_st[j] = to; x_st[j] = tx; y_st[j] = ty; i_st[j] = ti;
      end
      shelf = 0;
      while (1) begin
         skipped = 0;
         tallest = -1;
         cur_x   = 0;
         for (int i = held - 1; i >= 0; i--) begin
            if (o_st[i] != 0) continue;
            if (shelf + h_st[i] > bin_h || cur_x + w_st[i] > bin_w) begin
               skipped = 1;
               continue;
            end
            if (tallest < int'(h_st[i])) tallest = h_st[i];
            x_st[i] = cur_x[DimW-1:0];
            y_st[i] = shelf[DimW-1:0];
            o_st[i] = bin_id;
            cur_x += w_st[i];
         end
         if (skipped && tallest > 0) shelf += tallest;
         else break;
      end
      for (int k = 0; k < held; k++) begin
         p = '{i_st[k], w_st[k], h_st[k], x_st[k], y_st[k], o_st[k], k == held - 1};
         placements_q.push_back(p);
      end
      held = 0;
   endtask

   always @(posedge clock) begin
      placement_type want, got;
      if (reset) begin
         bin_w = '0; bin_h = '0; bin_id = 1; held = 0;
         placements_q.delete();
         mismatch_count  <= 0;
         placements_seen <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_BIN_WIDTH:  bin_w  = csr_wdata;
               CSR_BIN_HEIGHT: bin_h  = csr_wdata;
               CSR_BIN_NUMBER: bin_id = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[5:0], rsp_tdata[21:6], rsp_tdata[37:22], rsp_tdata[53:38],
                    rsp_tdata[69:54], rsp_tdata[85:70], rsp_tlast};
            placements_seen <= placements_seen + 1;
            if (placements_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result %p", $realtime, got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = placements_q.pop_front();
               if (want !== got || rsp_tdata[87:86] !== 2'b00) begin
                  if (mismatch_count < 10)
                     $display("%0t: result mismatch\n  exp %p\n  got %p", $realtime, want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            // drop the request once the store is full, but still honor tlast
            if (held < MaxRects) begin
               w_st[held] = req_tdata[15:0];
               h_st[held] = req_tdata[31:16];
               o_st[held] = req_tdata[47:32];
               x_st[held] = '0;
               y_st[held] = '0;
               i_st[held] = held[IdxW-1:0];
               held++;
            end
            if (req_tlast) pack_set();
         end
      end
      placements_due <= placements_q.size();
   end

endmodule

>>> tb/tb_shelf_rectangle_packer_unit.sv
module tb_shelf_rectangle_packer_unit;
   import srpk_pkg::*;

   localparam logic [CsrAddrW-1:0] CSR_SPARE = 2'd3;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tlast = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                csr_we = 0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [DimW-1:0]     csr_wdata = '0;

   int  mismatch_count, placements_due, placements_seen;
   logic req_fire_q = 0;
   int  sets_sent, rects_sent, stall_left, ready_pct, gap_pct;

   always #4 clock = ~clock;

   shelf_rectangle_packer_unit u_top (.*);

   srpk_checker u_checker (.*);

   always @(posedge clock) req_fire_q <= req_tvalid & req_tready;

   // receiver: random readiness with occasional long stalls
   initial begin
      stall_left = 0;
      ready_pct  = 100;
   end
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 99) < 2) begin
         stall_left = $urandom_range(10, 40);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r >= gap_pct) return 0;
      if (r < 3) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // called at a falling edge, returns at the falling edge after the request is taken, or after a random gap
   task automatic send_rect(input logic [15:0] w, h, prior, input logic last);
      int g;
      req_tvalid <= 1;
      req_tdata  <= {prior, h, w};
      req_tlast  <= last;
      do @(negedge clock); while (!req_fire_q);
      rects_sent++;
      if (last) sets_sent++;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [CsrAddrW-1:0] a, input logic [15:0] v);
      csr_we    <= 1;
      csr_addr  <= a;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 0;
      @(negedge clock);
   endtask

   // hold until every result is back and the block has settled
   task automatic drain();
      req_tvalid <= 0;
      do @(negedge clock); while (placements_due != 0);
      repeat (20) @(negedge clock);
      while (placements_due != 0) @(negedge clock);
   endtask

   task automatic set_bin(input logic [15:0] w, h, id);
      drain();
      write_csr(CSR_BIN_WIDTH, w);
      write_csr(CSR_BIN_HEIGHT, h);
      write_csr(CSR_BIN_NUMBER, id);
   endtask

   function automatic logic [15:0] pick_dim(input int span);
      if ($urandom_range(0, 3) == 0) return 16'($urandom());
      return 16'($urandom_range(0, span));
   endfunction

   task automatic random_set(input int n, input int span);
      logic [15:0] prior;
      for (int i = 0; i < n; i++) begin
         prior = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'd0;
         send_rect(pick_dim(span), pick_dim(span), prior, i == n - 1);
      end
   endtask

   initial begin
      int n, span;
      sets_sent  = 0;
      rects_sent = 0;
      gap_pct    = 30;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // extremes, ties of equal height, rectangles already owned
      set_bin(16'hFFFF, 16'hFFFF, 16'd1);
      send_rect(16'd0, 16'd0, 16'd0, 0);
      send_rect(16'hFFFF, 16'hFFFF, 16'd0, 0);
      send_rect(16'd5, 16'd7, 16'hFFFF, 0);
      send_rect(16'd9, 16'd7, 16'd0, 0);
      send_rect(16'd3, 16'd7, 16'd0, 1);
      send_rect(16'd1, 16'd1, 16'd0, 1);
      // zero bin number: placed rectangles stay free and move up every pass
      set_bin(16'd10, 16'd10, 16'd0);
      send_rect(16'd6, 16'd3, 16'd0, 0);
      send_rect(16'd6, 16'd3, 16'd0, 0);
      send_rect(16'd6, 16'd2, 16'd0, 1);
      // a pass placing only zero-height rectangles ends packing
      set_bin(16'd5, 16'd5, 16'hFFFF);
      send_rect(16'd4, 16'd0, 16'd0, 0);
      send_rect(16'd4, 16'd0, 16'd0, 0);
      send_rect(16'd2, 16'd9, 16'd0, 1);
      // empty bin, and a write to an unused index that must change nothing
      set_bin(16'd0, 16'd0, 16'h8000);
      write_csr(CSR_SPARE, 16'hFFFF);
      send_rect(16'd0, 16'd0, 16'd0, 0);
      send_rect(16'd1, 16'd1, 16'd0, 1);

      for (int s = 0; s < 14; s++) begin
         if (s % 4 == 0) begin
            span = (s % 8 == 0) ? 40 : 400;
            case ($urandom_range(0, 3))
               0: set_bin(16'hFFFF, 16'hFFFF, 16'($urandom_range(1, 65535)));
               1: set_bin(16'd0, pick_dim(100), 16'd0);
               default: set_bin(16'($urandom_range(span / 2, span * 2)),
                                16'($urandom_range(span / 2, span * 2)), 16'($urandom()));
            endcase
            gap_pct   = (s % 12 == 0) ? 0 : 35;
            ready_pct = (s % 12 == 0) ? 100 : $urandom_range(40, 95);
         end
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
         random_set(n, span);
      end
      // overfill the store: requests past the limit are dropped, tlast still packs
      set_bin(16'd300, 16'd300, 16'd3);
      random_set(MaxRects + 2, 60);

      drain();
      repeat (100) @(negedge clock);
      $display("Sent %0d rectangles in %0d sets, checked %0d placements.",
               rects_sent, sets_sent, placements_seen);
      $display("Covered edge bins, zero bin ids, zero heights, owned and overflow requests.");
      if (mismatch_count == 0 && placements_due == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #1000000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/srpk_pkg.sv
design/srpk_ram.sv
design/shelf_rectangle_packer_unit.sv
design/srpk_checker.sv
tb/srpk_checker.sv
tb/tb_shelf_rectangle_packer_unit.sv
